### rtl/olist_pkg.sv
`timescale 1ns / 1ps

package olist_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 5;
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int FIDX_W   = 4;
	localparam int TOTAL_W  = 5;

	typedef enum logic [3:0] {
		REQ_INS_HEAD = 4'd0,
		REQ_INS_TAIL = 4'd1,
		REQ_INS_POS  = 4'd2,
		REQ_DEL_HEAD = 4'd3,
		REQ_DEL_TAIL = 4'd4,
		REQ_DEL_POS  = 4'd5,
		REQ_CLEAR    = 4'd6,
		REQ_FIND     = 4'd7,
		REQ_READ     = 4'd8
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_MISS  = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [15:0] y;
		logic signed [15:0] x;
		logic        [31:0] tag;
		logic signed [31:0] key;
	} entry_t;

	// Broadcast to every cell; at doubles as the read index
	typedef struct packed {
		logic               en;
		logic               ins;
		logic               del;
		logic               find;
		logic               read;
		logic [IDX_W-1:0]   at;
		logic [CNT_W-1:0]   occ;
		logic signed [31:0] key;
	} cell_cmd_t;

	typedef struct packed {
		entry_t           entry;
		logic [IDX_W-1:0] idx;
	} cell_res_t;

endpackage

### rtl/olist_cell.sv
`timescale 1ns / 1ps

module olist_cell (
	input  logic                      clk,
	input  logic [olist_pkg::IDX_W-1:0] slot,
	input  olist_pkg::cell_cmd_t      cmd,
	input  olist_pkg::entry_t         fresh,
	input  olist_pkg::entry_t         left,
	input  olist_pkg::entry_t         right,
	input  logic                      hit_in,
	output logic                      hit_out,
	output olist_pkg::entry_t         entry,
	output olist_pkg::cell_res_t      result
);

	olist_pkg::entry_t entry_q;
	logic              live;
	logic              match;
	logic              sel;

	assign live    = olist_pkg::CNT_W'(slot) < cmd.occ;
	assign match   = cmd.find && live && (entry_q.key == cmd.key);
	assign hit_out = hit_in | match;
	assign sel     = (match && !hit_in) || (cmd.read && (slot == cmd.at));
	assign entry   = entry_q;

	always_comb begin
		result.entry = sel ? entry_q : '0;
		result.idx   = sel ? slot : '0;
	end

	// Insert pulls from the left neighbour, delete from the right
	always_ff @(posedge clk) begin
		if (cmd.en) begin
			if (cmd.ins) begin
				if (slot > cmd.at) begin
					entry_q <= left;
				end else if (slot == cmd.at) begin
					entry_q <= fresh;
				end
			end else if (cmd.del) begin
				if (slot >= cmd.at) begin
					entry_q <= right;
				end
			end
		end
	end

endmodule

### rtl/ordered_list_engine.sv
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY entries (key, shape tag, 12.4 x/y) held in a
// row of cells that shift left or right together on insert and delete, while
// every cell compares its key against a find request at once. A request beat
// is registered, executed once the output register is free or being taken,
// and its result held in that output register: one request per clock is
// sustained when the result side takes a beat every cycle. A stalled result
// holds one request in the input register; the next request is refused
// until that result leaves. Every request gives one result beat. Entry
// contents come out of reset undefined; only live entries are ever reported.
module ordered_list_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// position[4:0], key[36:5], shape_tag[68:37], target_x[84:69],
	// target_y[100:85], zero pad[103:101]
	input  logic [103:0]  s_axis_tdata,
	// req_type[3:0]
	input  logic [3:0]    s_axis_tuser,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// found_index[3:0], found_key[35:4], found_tag[67:36], found_x[83:68],
	// found_y[99:84], entry_total[104:100], zero pad[111:105]
	output logic [111:0]  m_axis_tdata,
	// status[1:0], found[2]
	output logic [2:0]    m_axis_tuser
);

	localparam int N = olist_pkg::CAPACITY;

	// request register
	logic                           busy_s1;
	olist_pkg::req_t                req_s1;
	logic [olist_pkg::POS_W-1:0]    pos_s1;
	olist_pkg::entry_t              fresh_s1;

	// list state and result register
	logic [olist_pkg::CNT_W-1:0]    occ_q;
	logic                           out_valid_q;
	olist_pkg::status_t             status_q;
	logic                           found_q;
	logic [olist_pkg::FIDX_W-1:0]   fidx_q;
	olist_pkg::entry_t              fentry_q;
	logic [olist_pkg::TOTAL_W-1:0]  total_q;

	logic                           exec;
	olist_pkg::cell_cmd_t           cmd;
	olist_pkg::status_t             status_nx;
	logic                           found_nx;
	logic [olist_pkg::CNT_W-1:0]    occ_nx;
	logic [olist_pkg::CMP_W-1:0]    occ_x;
	logic [olist_pkg::CMP_W-1:0]    pos_x;
	logic                           empty;
	logic                           full;

	olist_pkg::entry_t              cell_entry [N];
	olist_pkg::cell_res_t           cell_res   [N];
	logic [N:0]                     hit;
	olist_pkg::cell_res_t           pick;

	assign exec          = busy_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !busy_s1 || exec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			busy_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			req_s1       <= olist_pkg::req_t'(s_axis_tuser);
			pos_s1       <= s_axis_tdata[4:0];
			fresh_s1.key <= s_axis_tdata[36:5];
			fresh_s1.tag <= s_axis_tdata[68:37];
			fresh_s1.x   <= s_axis_tdata[84:69];
			fresh_s1.y   <= s_axis_tdata[100:85];
		end
	end

	assign occ_x = olist_pkg::CMP_W'(occ_q);
	assign pos_x = olist_pkg::CMP_W'(pos_s1);
	assign empty = (occ_q == '0);
	assign full  = (occ_q == olist_pkg::CNT_W'(N));

	always_comb begin
		cmd       = '0;
		cmd.en    = exec;
		cmd.occ   = occ_q;
		cmd.key   = fresh_s1.key;
		status_nx = olist_pkg::ST_OK;
		found_nx  = 1'b0;
		occ_nx    = occ_q;
		case (req_s1)
			olist_pkg::REQ_INS_HEAD, olist_pkg::REQ_INS_TAIL, olist_pkg::REQ_INS_POS: begin
				if (full) begin
					status_nx = olist_pkg::ST_FULL;
				end else begin
					cmd.ins = 1'b1;
					occ_nx  = occ_q + 1'b1;
					if (req_s1 == olist_pkg::REQ_INS_HEAD) begin
						cmd.at = '0;
					end else if (req_s1 == olist_pkg::REQ_INS_TAIL || pos_x >= occ_x) begin
						cmd.at = olist_pkg::IDX_W'(occ_q);
					end else begin
						cmd.at = olist_pkg::IDX_W'(pos_s1);
					end
				end
			end
			olist_pkg::REQ_DEL_HEAD, olist_pkg::REQ_DEL_TAIL: begin
				if (empty) begin
					status_nx = olist_pkg::ST_MISS;
				end else begin
					cmd.del = 1'b1;
					occ_nx  = occ_q - 1'b1;
					cmd.at  = (req_s1 == olist_pkg::REQ_DEL_HEAD) ? '0
					        : olist_pkg::IDX_W'(occ_q - 1'b1);
				end
			end
			olist_pkg::REQ_DEL_POS: begin
				if (empty) begin
					status_nx = olist_pkg::ST_MISS;
				end else if (pos_x >= occ_x) begin
					status_nx = olist_pkg::ST_RANGE;
				end else begin
					cmd.del = 1'b1;
					cmd.at  = olist_pkg::IDX_W'(pos_s1);
					occ_nx  = occ_q - 1'b1;
				end
			end
			olist_pkg::REQ_CLEAR: begin
				occ_nx = '0;
			end
			olist_pkg::REQ_FIND: begin
				cmd.find  = 1'b1;
				found_nx  = hit[N];
				status_nx = hit[N] ? olist_pkg::ST_OK : olist_pkg::ST_MISS;
			end
			olist_pkg::REQ_READ: begin
				if (empty) begin
					status_nx = olist_pkg::ST_MISS;
				end else if (pos_x >= occ_x) begin
					status_nx = olist_pkg::ST_RANGE;
				end else begin
					cmd.read = 1'b1;
					cmd.at   = olist_pkg::IDX_W'(pos_s1);
					found_nx = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign hit[0] = 1'b0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		olist_cell u_cell (
			.clk     (clk),
			.slot    (olist_pkg::IDX_W'(i)),
			.cmd     (cmd),
			.fresh   (fresh_s1),
			.left    (cell_entry[(i == 0) ? 0 : i - 1]),
			.right   (cell_entry[(i == N - 1) ? N - 1 : i + 1]),
			.hit_in  (hit[i]),
			.hit_out (hit[i + 1]),
			.entry   (cell_entry[i]),
			.result  (cell_res[i])
		);
	end

	// at most one cell selects, the rest drive zero
	always_comb begin
		pick = '0;
		for (int i = 0; i < N; i++) begin
			pick = pick | cell_res[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (exec) begin
				occ_q       <= occ_nx;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			status_q <= status_nx;
			found_q  <= found_nx;
			fidx_q   <= found_nx ? olist_pkg::FIDX_W'(pick.idx) : '0;
			fentry_q <= found_nx ? pick.entry : '0;
			total_q  <= olist_pkg::TOTAL_W'(occ_nx);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = {found_q, status_q};
	assign m_axis_tdata  = {7'd0, total_q, fentry_q.y, fentry_q.x, fentry_q.tag,
	                        fentry_q.key, fidx_q};

endmodule

### rtl/olist_chk.sv
`timescale 1ns / 1ps

module olist_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [111:0] m_axis_tdata,
	input logic [2:0]   m_axis_tuser
);

	localparam logic [4:0] CAP_TOTAL = 5'(olist_pkg::CAPACITY);

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == 2'd0)
		else $error("found reported with error status");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[2] |-> m_axis_tdata[99:0] == 100'd0)
		else $error("entry fields not cleared without a hit");

	a_full_total: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1:0] == 2'd3 |-> m_axis_tdata[104:100] == CAP_TOTAL)
		else $error("full status with list not full");

	a_total_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[104:100] <= CAP_TOTAL)
		else $error("entry count above capacity");

endmodule

bind ordered_list_engine olist_chk u_olist_chk (.*);
